// ----- hdl/nfa_pkg.sv -----
// Shared types and constants for the NFA word acceptor.
package nfa_pkg;

  localparam int STATE_W = 5;
  localparam int SYM_W   = 8;
  localparam int IDX_W   = 8;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FN_LOAD_TRANS = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_ALPHA = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SYMBOL     = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STATE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE    = 2'd3;

  localparam int TCNT_CFG_W = 9;
  localparam int ASIZE_CFG_W = 6;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [SYM_W-1:0]   symbol;
    logic [STATE_W-1:0] to_state;
  } trans_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } fsm_t;

endpackage

// ----- hdl/nfa_tables.sv -----
// Transition and alphabet memories, one write and one registered read port each.
module nfa_tables #(
  parameter int MAX_TRANSITIONS = 256,
  parameter int MAX_SYMBOLS     = 32,
  localparam int TIDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1,
  localparam int SIDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1
) (
  input  logic                      clk,
  input  logic                      t_we,
  input  logic [TIDX_W-1:0]         t_waddr,
  input  nfa_pkg::trans_t           t_wdata,
  input  logic [TIDX_W-1:0]         t_raddr,
  output nfa_pkg::trans_t           t_rdata,
  input  logic                      a_we,
  input  logic [SIDX_W-1:0]         a_waddr,
  input  logic [nfa_pkg::SYM_W-1:0] a_wdata,
  input  logic [SIDX_W-1:0]         a_raddr,
  output logic [nfa_pkg::SYM_W-1:0] a_rdata
);
  import nfa_pkg::*;

  trans_t           tmem [MAX_TRANSITIONS];
  logic [SYM_W-1:0] amem [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    t_rdata <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    a_rdata <= amem[a_raddr];
  end

endmodule

// ----- hdl/nfa_word_acceptor.sv -----
// Top level of the NFA word acceptor: sequencer, active set and result register.
//
//  channel  dir  signals                                  transaction
//  in_      in   in_tvalid/in_tready/in_tdata/in_tuser/   one load or word symbol
//                in_tlast
//  out_     out  out_tvalid/out_tready/out_tdata          one word verdict
//  cfg_     in   cfg_we/cfg_index/cfg_wdata               one register write
//
// Loads and func 3 are taken while idle. A word symbol runs a table scan over
// max(na, nt) entries, na and nt being the alphabet size and transition count in use;
// the scan reads one alphabet and one transition entry per cycle from the memories, and
// a drain step updates the active set. A symbol of a stopped word skips the scan. Reset
// is synchronous and needs no clearing pass. The verdict waits in an output register;
// a stalled output only holds the sequencer on a last symbol while the register is full.
module nfa_word_acceptor #(
  parameter int NUM_STATES      = 32,
  parameter int MAX_TRANSITIONS = 256,
  parameter int MAX_SYMBOLS     = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // entry_index[7:0], from_state[12:8], to_state[17:13], symbol[25:18], zero[31:26]
  input  logic [nfa_pkg::IN_TDATA_W-1:0] in_tdata,
  // func[1:0]
  input  logic [nfa_pkg::FUNC_W-1:0]     in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // accepted[0], bad_letter[1], zero[7:2]
  output logic [nfa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nfa_pkg::*;

  localparam int TIDX_W = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int SIDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int LMAX   = (MAX_TRANSITIONS > MAX_SYMBOLS) ? MAX_TRANSITIONS : MAX_SYMBOLS;
  localparam int CNT_W  = $clog2(LMAX + 1);

  function automatic logic [NUM_STATES-1:0] st_bit(input logic [STATE_W-1:0] s);
    logic [NUM_STATES-1:0] b;
    for (int i = 0; i < NUM_STATES; i++) begin
      b[i] = ({1'b0, s} == (STATE_W+1)'(i));
    end
    return b;
  endfunction

  // input fields
  logic [IDX_W-1:0]   in_idx;
  logic [STATE_W-1:0] in_from;
  logic [STATE_W-1:0] in_to;
  logic [SYM_W-1:0]   in_sym;
  assign in_idx  = in_tdata[7:0];
  assign in_from = in_tdata[12:8];
  assign in_to   = in_tdata[17:13];
  assign in_sym  = in_tdata[25:18];

  // configuration
  logic [STATE_W-1:0]     init_r;
  logic [CFG_DATA_W-1:0]  fmask_r;
  logic [TCNT_CFG_W-1:0]  tcnt_r;
  logic [ASIZE_CFG_W-1:0] asize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r  <= '0;
      fmask_r <= '0;
      tcnt_r  <= '0;
      asize_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL_STATE:    init_r  <= cfg_wdata[STATE_W-1:0];
        CFG_FINAL_MASK:       fmask_r <= cfg_wdata;
        CFG_TRANSITION_COUNT: tcnt_r  <= cfg_wdata[TCNT_CFG_W-1:0];
        CFG_ALPHABET_SIZE:    asize_r <= cfg_wdata[ASIZE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] nt;
  logic [CNT_W-1:0] na;
  logic [CNT_W-1:0] len;
  assign nt  = (32'(tcnt_r) > MAX_TRANSITIONS) ? CNT_W'(MAX_TRANSITIONS) : CNT_W'(tcnt_r);
  assign na  = (32'(asize_r) > MAX_SYMBOLS) ? CNT_W'(MAX_SYMBOLS) : CNT_W'(asize_r);
  assign len = (nt > na) ? nt : na;

  // sequencer state
  fsm_t                  state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [SYM_W-1:0]      sym_r;
  logic                  last_r;
  logic [NUM_STATES-1:0] active_r;
  logic                  stopped_r;
  logic                  mid_r;
  logic                  known_r;
  logic [NUM_STATES-1:0] next_r;
  logic                  rd_a_r;
  logic                  rd_t_r;
  logic                  out_valid_r;
  logic                  out_acc_r;
  logic                  out_bad_r;

  logic                  acc_in;
  logic                  acc_word;
  logic                  eff_stopped;
  logic                  scan_end;
  logic                  out_free;
  logic                  issue;
  logic                  emit;

  trans_t                t_rdata;
  logic [SYM_W-1:0]      a_rdata;
  trans_t                t_wdata;
  logic                  t_we;
  logic                  a_we;

  logic                  hit_a;
  logic [NUM_STATES-1:0] tgt;
  logic                  known_fin;
  logic [NUM_STATES-1:0] next_fin;
  logic [NUM_STATES-1:0] fmask_st;

  assign acc_in      = in_tvalid && in_tready;
  assign acc_word    = acc_in && (in_tuser == FN_SYMBOL);
  assign eff_stopped = mid_r && stopped_r;
  assign scan_end    = ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(1)) >= (CNT_W+1)'(len);
  assign out_free    = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_word) begin
          if (eff_stopped) begin
            state_nxt = in_tlast ? ST_DONE : ST_IDLE;
          end else begin
            state_nxt = (len == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = last_r ? ST_DONE : ST_IDLE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == ST_IDLE);
    issue     = (state_r == ST_SCAN);
    emit      = (state_r == ST_DONE) && out_free;
  end

  // table writes
  assign t_wdata.from_state = in_from;
  assign t_wdata.symbol     = in_sym;
  assign t_wdata.to_state   = in_to;
  assign t_we = acc_in && (in_tuser == FN_LOAD_TRANS) && (32'(in_idx) < MAX_TRANSITIONS);
  assign a_we = acc_in && (in_tuser == FN_LOAD_ALPHA) && (32'(in_idx) < MAX_SYMBOLS);

  nfa_tables #(
    .MAX_TRANSITIONS(MAX_TRANSITIONS),
    .MAX_SYMBOLS    (MAX_SYMBOLS)
  ) u_tables (
    .clk    (clk),
    .t_we   (t_we),
    .t_waddr(TIDX_W'(in_idx)),
    .t_wdata(t_wdata),
    .t_raddr(cnt_r[TIDX_W-1:0]),
    .t_rdata(t_rdata),
    .a_we   (a_we),
    .a_waddr(SIDX_W'(in_idx)),
    .a_wdata(in_sym),
    .a_raddr(cnt_r[SIDX_W-1:0]),
    .a_rdata(a_rdata)
  );

  // match logic on the entries read last cycle
  assign hit_a = rd_a_r && (a_rdata == sym_r);
  assign tgt   = (rd_t_r && (t_rdata.symbol == sym_r) &&
                  |(active_r & st_bit(t_rdata.from_state))) ?
                 st_bit(t_rdata.to_state) : '0;
  assign known_fin = known_r | hit_a;
  assign next_fin  = next_r | tgt;
  assign fmask_st  = NUM_STATES'(fmask_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mid_r       <= 1'b0;
      stopped_r   <= 1'b0;
      active_r    <= st_bit('0);
      rd_a_r      <= 1'b0;
      rd_t_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_a_r  <= issue && (cnt_r < na);
      rd_t_r  <= issue && (cnt_r < nt);
      if (acc_word && !mid_r) begin
        active_r  <= st_bit(init_r);
        stopped_r <= 1'b0;
        mid_r     <= 1'b1;
      end else if (state_r == ST_DRAIN) begin
        if (known_fin) begin
          active_r <= next_fin;
        end
        stopped_r <= !known_fin;
      end else if (emit) begin
        active_r  <= st_bit(init_r);
        stopped_r <= 1'b0;
        mid_r     <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_word) begin
      sym_r   <= in_sym;
      last_r  <= in_tlast;
      cnt_r   <= '0;
      known_r <= 1'b0;
      next_r  <= '0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      known_r <= known_fin;
      next_r  <= next_fin;
    end
    if (emit) begin
      out_acc_r <= |(active_r & fmask_st);
      out_bad_r <= stopped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_bad_r, out_acc_r};

endmodule
